// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk while out of reset.
`define EWG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every rising edge of aclk, reset included.
`define EWG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: src/ewg_pkg.sv
// ----------------------------------------------------------------------------
// ewg_pkg
// Types, constants and table functions of the edge weight generator.
// ----------------------------------------------------------------------------
package ewg_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_BETA        = 2'd1,
        CFG_GAMMA       = 2'd2
    } cfg_index_t;

    localparam logic [11:0] WIDTH_RST = 12'd640;
    localparam logic [31:0] BETA_RST  = 32'd0;
    localparam logic [23:0] GAMMA_RST = 24'd12800;

    // log2(e) in Q32
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       frame_start;
    } ewg_in_t;

    typedef struct packed {
        logic [23:0] left_weight;
        logic [23:0] upleft_weight;
        logic [23:0] up_weight;
        logic [23:0] upright_weight;
    } ewg_out_t;

    typedef struct packed {
        logic [11:0] image_width;
        logic [31:0] beta_q24;
        logic [23:0] gamma_q8;
    } ewg_cfg_t;

    typedef enum logic [1:0] {
        EDGE_LEFT    = 2'd0,
        EDGE_UPLEFT  = 2'd1,
        EDGE_UP      = 2'd2,
        EDGE_UPRIGHT = 2'd3
    } edge_t;

    // One classified pixel with its neighbors; en bit per edge_t code
    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] prev;
        logic [7:0] upleft;
        logic [7:0] up;
        logic [7:0] upright;
        logic [3:0] en;
    } ewg_job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RD_UP,
        F_RD_UR,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIFF,
        B_SQUARE,
        B_EXPO,
        B_RANGE,
        B_ITER,
        B_SCALE,
        B_OUT
    } back_state_t;

    typedef logic [32:0][31:0] roots_t;

    function automatic logic [63:0] isqrt_round(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        if (rem > res) begin
            res = res + 64'd1;
        end
        return res;
    endfunction

    // Entry j is 2^(-2^-j) in Q31
    function automatic roots_t build_roots();
        roots_t      r;
        logic [63:0] s;
        r    = '0;
        r[0] = 32'd1 << 30;
        for (int j = 1; j <= 32; j++) begin
            s    = isqrt_round({1'b0, r[j-1], 31'b0});
            r[j] = s[31:0];
        end
        return r;
    endfunction

    localparam roots_t ROOT_TAB = build_roots();

endpackage

// File: src/graph_cut_edge_weight_gen.sv
// ----------------------------------------------------------------------------
// graph_cut_edge_weight_gen
// 8-neighbour graph-cut edge weights from a raster stream of grey pixels.
// ----------------------------------------------------------------------------
// For each pixel the block returns the left, up-left, up and up-right weights
// gamma * 2^(-beta * d * d * log2(e)) in Q16.8, diagonals scaled by 1/sqrt(2),
// and 0 where the neighbour lies outside the image. The front takes one pixel
// at a time, with two reads and one write of the one-port-each line store.
// The back runs each enabled edge through one shared exp unit built on 32
// iterations of a 32x32 multiply; a two-entry queue lets the front run ahead.
// Configuration is written through cfg_* and is always ready.
module graph_cut_edge_weight_gen #(
    parameter int MAX_WIDTH = ewg_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ewg_pkg::ewg_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ewg_pkg::ewg_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ewg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    import ewg_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    ewg_cfg_t cfg_reg, cfg_next;

    logic          q_space;
    logic          push;
    ewg_job_t      push_job;
    logic          pop;
    ewg_job_t      pop_job;
    logic          avail;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH: cfg_next.image_width = cfg_data[11:0];
                CFG_BETA:        cfg_next.beta_q24    = cfg_data;
                CFG_GAMMA:       cfg_next.gamma_q8    = cfg_data[23:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width <= WIDTH_RST;
            cfg_reg.beta_q24    <= BETA_RST;
            cfg_reg.gamma_q8    <= GAMMA_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ewg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ewg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg      (cfg_reg),
        .q_space  (q_space),
        .push     (push),
        .push_job (push_job),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    ewg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .space    (q_space),
        .pop      (pop),
        .pop_job  (pop_job),
        .avail    (avail)
    );

    ewg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .avail   (avail),
        .pop_job (pop_job),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: src/ewg_ram.sv
// ----------------------------------------------------------------------------
// ewg_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ewg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/ewg_front.sv
// ----------------------------------------------------------------------------
// ewg_front
// Accepts pixels, tracks row and column, fetches the row above and
// hands a classified job to the queue.
// ----------------------------------------------------------------------------
module ewg_front #(
    parameter int MAX_WIDTH = ewg_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ewg_pkg::ewg_in_t             s_data,
    input  ewg_pkg::ewg_cfg_t            cfg,
    input  logic                         q_space,
    output logic                         push,
    output ewg_pkg::ewg_job_t            push_job,
    output logic                         wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    output logic [7:0]                   wr_data,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [7:0]                   rd_data
);

    import ewg_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    front_state_t  state_reg, state_next;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic          first_row_reg, first_row_next;
    logic [CW-1:0] item_col_reg, item_col_next;
    logic          item_first_reg, item_first_next;
    logic          item_last_reg, item_last_next;
    logic [7:0]    pix_reg, pix_next;
    logic [7:0]    prev_reg, prev_next;
    logic [7:0]    upleft_reg, upleft_next;
    logic [7:0]    up_reg, up_next;

    logic [CW-1:0] w_eff;
    logic [CW-1:0] col;
    logic          first;
    logic [CW-1:0] col_p1;
    logic [CW-1:0] item_col_p1;
    logic          last;
    logic          accept;

    always_comb begin
        if (cfg.image_width == 12'd0) begin
            w_eff = CW'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(cfg.image_width);
        end
    end

    assign s_ready     = (state_reg == F_IDLE) && q_space;
    assign accept      = s_valid && s_ready;
    assign item_col_p1 = item_col_reg + CW'(1);

    always_comb begin
        priority if (s_data.frame_start) begin
            col   = '0;
            first = 1'b1;
        end else if (col_cnt_reg >= w_eff) begin
            col   = '0;
            first = 1'b0;
        end else begin
            col   = col_cnt_reg;
            first = first_row_reg;
        end
        col_p1 = col + CW'(1);
        last   = col_p1 >= w_eff;
    end

    always_comb begin
        state_next      = state_reg;
        col_cnt_next    = col_cnt_reg;
        first_row_next  = first_row_reg;
        item_col_next   = item_col_reg;
        item_first_next = item_first_reg;
        item_last_next  = item_last_reg;
        pix_next        = pix_reg;
        prev_next       = prev_reg;
        upleft_next     = upleft_reg;
        up_next         = up_reg;
        push            = 1'b0;
        wr_en           = 1'b0;
        rd_addr         = item_col_reg[AW-1:0];
        push_job        = '0;

        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    item_col_next   = col;
                    item_first_next = first;
                    item_last_next  = last;
                    pix_next        = s_data.pixel_value;
                    col_cnt_next    = last ? '0 : col_p1;
                    first_row_next  = last ? 1'b0 : first;
                    state_next      = F_RD_UP;
                end
            end
            F_RD_UP: begin
                state_next = F_RD_UR;
            end
            F_RD_UR: begin
                up_next    = rd_data;
                rd_addr    = item_col_p1[AW-1:0];
                state_next = F_PUSH;
            end
            F_PUSH: begin
                push             = 1'b1;
                push_job.pixel   = pix_reg;
                push_job.prev    = prev_reg;
                push_job.upleft  = upleft_reg;
                push_job.up      = up_reg;
                push_job.upright = rd_data;
                push_job.en[EDGE_LEFT]    = item_col_reg != '0;
                push_job.en[EDGE_UPLEFT]  = !item_first_reg && (item_col_reg != '0);
                push_job.en[EDGE_UP]      = !item_first_reg;
                push_job.en[EDGE_UPRIGHT] = !item_first_reg && !item_last_reg;
                wr_en       = 1'b1;
                prev_next   = pix_reg;
                upleft_next = item_first_reg ? 8'd0 : up_reg;
                state_next  = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign wr_addr = item_col_reg[AW-1:0];
    assign wr_data = pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            col_cnt_reg   <= '0;
            first_row_reg <= 1'b1;
            prev_reg      <= '0;
            upleft_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            col_cnt_reg   <= col_cnt_next;
            first_row_reg <= first_row_next;
            prev_reg      <= prev_next;
            upleft_reg    <= upleft_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_col_reg   <= item_col_next;
        item_first_reg <= item_first_next;
        item_last_reg  <= item_last_next;
        pix_reg        <= pix_next;
        up_reg         <= up_next;
    end

endmodule

// File: src/ewg_queue.sv
// ----------------------------------------------------------------------------
// ewg_queue
// Short FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module ewg_queue #(
    parameter int DEPTH = ewg_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ewg_pkg::ewg_job_t push_job,
    output logic              space,
    input  logic              pop,
    output ewg_pkg::ewg_job_t pop_job,
    output logic              avail
);

    import ewg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    ewg_job_t      slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign space   = count_reg < NW'(DEPTH);
    assign avail   = count_reg != '0;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: src/ewg_back.sv
// ----------------------------------------------------------------------------
// ewg_back
// Computes the left, up-left, up and up-right weights of a job with a shared exp unit
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module ewg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ewg_pkg::ewg_cfg_t  cfg,
    input  logic               avail,
    input  ewg_pkg::ewg_job_t  pop_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ewg_pkg::ewg_out_t  m_data
);

    import ewg_pkg::*;

    back_state_t       state_reg, state_next;
    ewg_job_t          job_reg, job_next;
    edge_t             edge_reg, edge_next;
    logic [15:0]       dsq_reg, dsq_next;
    logic [47:0]       x_reg, x_next;
    logic [61:0]       t_reg, t_next;
    logic [4:0]        k_reg, k_next;
    logic [31:0]       m_reg, m_next;
    logic [55:0]       prod_reg, prod_next;
    logic [3:0][23:0]  wt_reg, wt_next;
    logic              m_valid_reg, m_valid_next;
    ewg_out_t          m_data_reg, m_data_next;

    logic [7:0]  nb;
    logic [7:0]  d;
    logic        diag;
    logic        done_edge;
    logic [23:0] done_val;
    logic [31:0] frac;
    logic [63:0] step_prod;
    logic [55:0] shifted;

    // Result handoff: park a finished result until the output register is free
    logic result_ready;
    logic hold_result;
    logic pend_reg, pend_next;

    always_comb begin
        unique case (edge_reg)
            EDGE_LEFT:    nb = job_reg.prev;
            EDGE_UPLEFT:  nb = job_reg.upleft;
            EDGE_UP:      nb = job_reg.up;
            EDGE_UPRIGHT: nb = job_reg.upright;
            default:      nb = job_reg.up;
        endcase
    end

    assign diag      = (edge_reg == EDGE_UPLEFT) || (edge_reg == EDGE_UPRIGHT);
    assign d         = (job_reg.pixel > nb) ? job_reg.pixel - nb : nb - job_reg.pixel;
    assign frac      = t_reg[55:24];
    assign step_prod = m_reg * ROOT_TAB[6'(k_reg) + 6'd1] + (64'd1 << 30);
    assign shifted   = prod_reg >> (7'd31 + 7'(t_reg[60:56]));

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        edge_next    = edge_reg;
        dsq_next     = dsq_reg;
        x_next       = x_reg;
        t_next       = t_reg;
        k_next       = k_reg;
        m_next       = m_reg;
        prod_next    = prod_reg;
        wt_next      = wt_reg;
        m_valid_next = m_valid_reg;
        pop          = 1'b0;
        done_edge    = 1'b0;
        done_val     = '0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE: begin
                // hold the queue while a finished result still waits
                if (avail && !pend_reg) begin
                    pop        = 1'b1;
                    job_next   = pop_job;
                    edge_next  = EDGE_LEFT;
                    state_next = B_DIFF;
                end
            end
            B_DIFF: begin
                if (!job_reg.en[edge_reg]) begin
                    done_edge = 1'b1;
                end else begin
                    dsq_next   = d * d;
                    state_next = B_SQUARE;
                end
            end
            B_SQUARE: begin
                x_next     = cfg.beta_q24 * dsq_reg;
                state_next = B_EXPO;
            end
            B_EXPO: begin
                if (x_reg[47:29] != '0) begin
                    done_edge = 1'b1;
                end else begin
                    t_next = 62'(x_reg[28:0]) * 62'(LOG2E_Q32)
                           + (diag ? (62'd1 << 55) : 62'd0);
                    state_next = B_RANGE;
                end
            end
            B_RANGE: begin
                // shift count of 32 or more leaves nothing
                if (t_reg[61]) begin
                    done_edge = 1'b1;
                end else begin
                    m_next     = 32'h8000_0000;
                    k_next     = '0;
                    state_next = B_ITER;
                end
            end
            B_ITER: begin
                if (frac[5'd31 - k_reg]) begin
                    m_next = step_prod[62:31];
                end
                if (k_reg == 5'd31) begin
                    state_next = B_SCALE;
                end else begin
                    k_next = k_reg + 5'd1;
                end
            end
            B_SCALE: begin
                prod_next  = cfg.gamma_q8 * m_reg;
                state_next = B_OUT;
            end
            B_OUT: begin
                done_edge = 1'b1;
                done_val  = shifted[23:0];
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        if (done_edge) begin
            wt_next[edge_reg] = done_val;
            if (edge_reg == EDGE_UPRIGHT) begin
                state_next = B_IDLE;
            end else begin
                edge_next  = edge_t'(2'(edge_reg) + 2'd1);
                state_next = B_DIFF;
            end
        end
    end

    assign result_ready = done_edge && (edge_reg == EDGE_UPRIGHT);
    assign hold_result  = result_ready && m_valid_reg && !m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (pend_reg && (!m_valid_reg || m_ready)) begin
            pend_next = 1'b0;
        end
        if (hold_result) begin
            pend_next = 1'b1;
        end
    end

    always_comb begin
        if (pend_reg && (!m_valid_reg || m_ready)) begin
            m_data_next.left_weight    = wt_reg[EDGE_LEFT];
            m_data_next.upleft_weight  = wt_reg[EDGE_UPLEFT];
            m_data_next.up_weight      = wt_reg[EDGE_UP];
            m_data_next.upright_weight = wt_reg[EDGE_UPRIGHT];
        end else if (result_ready && !hold_result) begin
            m_data_next.left_weight    = wt_next[EDGE_LEFT];
            m_data_next.upleft_weight  = wt_next[EDGE_UPLEFT];
            m_data_next.up_weight      = wt_next[EDGE_UP];
            m_data_next.upright_weight = wt_next[EDGE_UPRIGHT];
        end else begin
            m_data_next = m_data_reg;
        end
    end

    logic load_out;
    logic stall_back;

    assign load_out   = (pend_reg && (!m_valid_reg || m_ready)) ||
                        (result_ready && !hold_result);
    assign stall_back = pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            if (!(stall_back && state_reg == B_IDLE)) begin
                state_reg <= state_next;
            end
            m_valid_reg <= load_out ? 1'b1 : m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!(stall_back && state_reg == B_IDLE)) begin
            job_reg  <= job_next;
            edge_reg <= edge_next;
            wt_reg   <= wt_next;
        end
        dsq_reg    <= dsq_next;
        x_reg      <= x_next;
        t_reg      <= t_next;
        k_reg      <= k_next;
        m_reg      <= m_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/ewg_checker.sv
// ----------------------------------------------------------------------------
// ewg_checker
// Port-level checks of the edge weight generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ewg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input ewg_pkg::ewg_in_t              s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input ewg_pkg::ewg_out_t             m_data,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [ewg_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [31:0]                   cfg_data
);

    // hold a stalled result
    `EWG_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result lost")
    // hold a waiting request
    `EWG_ASSERT(a_request_hold, s_valid && !s_ready |=> s_valid && $stable(s_data), "request lost")
    // drop ready only after taking a request
    `EWG_ASSERT(a_ready_fall, $fell(s_ready) |-> $past(s_valid && s_ready), "s_ready fell")
    `EWG_ASSERT(a_cfg_write, cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}), "cfg")
    `EWG_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind graph_cut_edge_weight_gen ewg_checker u_ewg_checker (.*);

// File: tb/graph_cut_edge_weight_gen_tb.sv
// ----------------------------------------------------------------------------
// graph_cut_edge_weight_gen_tb
// Self-checking bench for the edge weight generator: a directed table of
// pixels and register writes, then random raster phases under several
// width, beta and gamma settings. Every accepted pixel is predicted here and
// each returned weight set is compared with the oldest expected set.
// ----------------------------------------------------------------------------
module graph_cut_edge_weight_gen_tb;
    import ewg_pkg::*;

    localparam int      STORE_DEPTH = 2048;
    localparam int      DRAIN_WAIT  = 200;
    localparam int      CYCLE_LIMIT = 800000;
    localparam int      RAND_ITEMS  = 800;
    localparam longint unsigned LOG2E = 64'd6196328019;

    typedef struct {
        bit         is_cfg;
        cfg_index_t idx;
        logic [31:0] val;
        ewg_in_t    pix;
        bit         typed;
        ewg_out_t   want;
    } step_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ewg_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    ewg_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    graph_cut_edge_weight_gen DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    longint unsigned roots[33];
    logic [7:0]  row_above[STORE_DEPTH];
    bit          row_filled[STORE_DEPTH];
    logic [7:0]  prev_pix;
    logic [7:0]  upleft_pix;
    int          col_idx;
    bit          top_row;
    logic [11:0] width_reg;
    logic [31:0] beta_reg;
    logic [23:0] gamma_reg;

    ewg_out_t weight_q[$];
    int  errors = 0;
    int  pixels_sent = 0;
    int  sets_checked = 0;
    int  reg_writes = 0;
    bit  quiet = 0;
    bit  held_off = 0;
    bit  in_batch = 0;

    function automatic longint unsigned round_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic logic [23:0] edge_weight(logic [7:0] a, logic [7:0] b, bit diag);
        longint unsigned d;
        longint unsigned x;
        longint unsigned t;
        longint unsigned n;
        longint unsigned f;
        longint unsigned m;
        d = (a > b) ? a - b : b - a;
        x = longint'(beta_reg) * (d * d);
        if (x >= (64'd1 << 29)) return '0;
        t = x * LOG2E;
        if (diag) t += 64'd1 << 55;
        n = t >> 56;
        if (n >= 32) return '0;
        f = (t >> 24) & 64'hFFFF_FFFF;
        m = 64'd1 << 31;
        for (int j = 1; j <= 32; j++) begin
            if ((f >> (32 - j)) & 1) m = (m * roots[j] + (64'd1 << 30)) >> 31;
        end
        return 24'((longint'(gamma_reg) * m) >> (31 + n));
    endfunction

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > STORE_DEPTH) w = STORE_DEPTH;
        return w;
    endfunction

    // True when a pixel without frame start would read a never-written entry
    function automatic bit needs_restart();
        int w;
        int c;
        bit fr;
        w = eff_width();
        c = col_idx;
        fr = top_row;
        if (c >= w) begin
            c = 0;
            fr = 0;
        end
        if (fr) return 0;
        if (!row_filled[c]) return 1;
        return (c + 1 < w) && !row_filled[c + 1];
    endfunction

    function automatic ewg_out_t predict_weights(ewg_in_t p);
        ewg_out_t r;
        int w;
        logic [7:0] up;
        w = eff_width();
        r = '0;
        up = '0;
        if (p.frame_start) begin
            col_idx = 0;
            top_row = 1;
        end else if (col_idx >= w) begin
            col_idx = 0;
            top_row = 0;
        end
        if (col_idx > 0) r.left_weight = edge_weight(p.pixel_value, prev_pix, 0);
        if (!top_row) begin
            up = row_above[col_idx];
            r.up_weight = edge_weight(p.pixel_value, up, 0);
            if (col_idx > 0) r.upleft_weight = edge_weight(p.pixel_value, upleft_pix, 1);
            if (col_idx + 1 < w)
                r.upright_weight = edge_weight(p.pixel_value, row_above[col_idx + 1], 1);
        end
        upleft_pix = up;
        row_above[col_idx] = p.pixel_value;
        row_filled[col_idx] = 1;
        prev_pix = p.pixel_value;
        if (col_idx + 1 >= w) begin
            col_idx = 0;
            top_row = 0;
        end else begin
            col_idx++;
        end
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[graph_cut_edge_weight_gen] ERROR");
        $finish;
    end

    // result side: check at the rising edge, pick ready at the falling edge
    initial begin
        int stall;
        stall = 0;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (weight_q.size() == 0) begin
                    $error("result with no pending request");
                    errors++;
                end else begin
                    ewg_out_t w;
                    w = weight_q.pop_front();
                    if (m_data.left_weight !== w.left_weight) begin
                        $error("left_weight exp %0d got %0d", w.left_weight, m_data.left_weight);
                        errors++;
                    end
                    if (m_data.upleft_weight !== w.upleft_weight) begin
                        $error("upleft_weight exp %0d got %0d",
                               w.upleft_weight, m_data.upleft_weight);
                        errors++;
                    end
                    if (m_data.up_weight !== w.up_weight) begin
                        $error("up_weight exp %0d got %0d", w.up_weight, m_data.up_weight);
                        errors++;
                    end
                    if (m_data.upright_weight !== w.upright_weight) begin
                        $error("upright_weight exp %0d got %0d",
                               w.upright_weight, m_data.upright_weight);
                        errors++;
                    end
                end
                sets_checked++;
            end
            @(negedge aclk);
            // one long hold-off so the block backs up into its input
            if (!held_off && sets_checked >= 300 && in_batch) begin
                held_off = 1;
                stall = 400;
            end
            if (stall > 0) begin
                m_ready = 0;
                stall--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready = 0;
                stall = $urandom_range(0, 2);
            end else begin
                m_ready = aresetn;
            end
        end
    end

    task automatic send_pixel(logic [7:0] pv, bit fs, bit typed, ewg_out_t want);
        ewg_in_t p;
        ewg_out_t pred;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        p.pixel_value = pv;
        p.frame_start = fs | needs_restart();
        s_data = p;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        pred = predict_weights(p);
        weight_q.insert(weight_q.size(), typed ? want : pred);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 0;
        while (weight_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH: width_reg = val[11:0];
            CFG_BETA:        beta_reg = val;
            CFG_GAMMA:       gamma_reg = val[23:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    function automatic step_row_t px(logic [7:0] v, bit fs);
        step_row_t r;
        r = '{is_cfg: 0, idx: CFG_IMAGE_WIDTH, val: '0, pix: '0, typed: 0, want: '0};
        r.pix.pixel_value = v;
        r.pix.frame_start = fs;
        return r;
    endfunction

    function automatic step_row_t px_typed(logic [7:0] v, bit fs, logic [23:0] lw);
        step_row_t r;
        r = px(v, fs);
        r.typed = 1;
        r.want.left_weight = lw;
        return r;
    endfunction

    function automatic step_row_t wr(cfg_index_t idx, logic [31:0] val);
        step_row_t r;
        r = '{is_cfg: 0, idx: CFG_IMAGE_WIDTH, val: '0, pix: '0, typed: 0, want: '0};
        r.is_cfg = 1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    initial begin
        step_row_t table_rows[$];
        int rnd;
        int n_items;
        int k;
        logic [7:0] pv;
        int step;

        roots[0] = 64'd1 << 30;
        for (int j = 1; j <= 32; j++) roots[j] = round_sqrt(roots[j - 1] << 31);
        for (int i = 0; i < STORE_DEPTH; i++) begin
            row_above[i] = '0;
            row_filled[i] = 0;
        end
        prev_pix = '0;
        upleft_pix = '0;
        col_idx = 0;
        top_row = 1;
        width_reg = WIDTH_RST;
        beta_reg = BETA_RST;
        gamma_reg = GAMMA_RST;

        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // reset settings: beta 0 gives the full gamma on every inner left and up edge
        table_rows.insert(table_rows.size(), px_typed(8'd255, 0, 24'd0));
        table_rows.insert(table_rows.size(), px_typed(8'd0, 0, 24'd12800));
        table_rows.insert(table_rows.size(), px_typed(8'd0, 1, 24'd0));
        table_rows.insert(table_rows.size(), px_typed(8'd7, 0, 24'd12800));
        table_rows.insert(table_rows.size(), wr(CFG_IMAGE_WIDTH, 32'd3));
        table_rows.insert(table_rows.size(), wr(CFG_GAMMA, 32'hFF_FFFF));
        for (int i = 0; i < 9; i++)
            table_rows.insert(table_rows.size(), px(i[0] ? 8'd255 : 8'd0, i == 0));
        // width 0 behaves as a single column; max beta kills every weight between unequal pixels
        table_rows.insert(table_rows.size(), wr(CFG_IMAGE_WIDTH, 32'd0));
        table_rows.insert(table_rows.size(), wr(CFG_BETA, 32'hFFFF_FFFF));
        table_rows.insert(table_rows.size(), px(8'd10, 1));
        table_rows.insert(table_rows.size(), px(8'd10, 0));
        table_rows.insert(table_rows.size(), px(8'd11, 0));
        // oversized width saturates
        table_rows.insert(table_rows.size(), wr(CFG_IMAGE_WIDTH, 32'd4095));
        table_rows.insert(table_rows.size(), wr(CFG_BETA, 32'd1 << 20));
        table_rows.insert(table_rows.size(), wr(CFG_GAMMA, 32'd0));
        table_rows.insert(table_rows.size(), px(8'd1, 1));
        table_rows.insert(table_rows.size(), px(8'd4, 0));
        table_rows.insert(table_rows.size(), wr(CFG_GAMMA, 32'd256));
        table_rows.insert(table_rows.size(), px(8'd9, 0));
        table_rows.insert(table_rows.size(), px(8'd200, 0));

        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg) begin
                drain();
                write_reg(table_rows[i].idx, table_rows[i].val);
            end else begin
                send_pixel(table_rows[i].pix.pixel_value, table_rows[i].pix.frame_start,
                           table_rows[i].typed, table_rows[i].want);
            end
        end

        rnd = 0;
        pv = 8'd128;
        while (rnd < RAND_ITEMS) begin
            drain();
            case ($urandom_range(0, 7))
                0: write_reg(CFG_IMAGE_WIDTH, 32'd2048);
                1: write_reg(CFG_IMAGE_WIDTH, 32'd1);
                2: write_reg(CFG_IMAGE_WIDTH, $urandom_range(2, 4));
                default: write_reg(CFG_IMAGE_WIDTH, $urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_BETA, 32'd0);
                1: write_reg(CFG_BETA, $urandom());
                2: write_reg(CFG_BETA, 32'hFFFF_FFFF);
                default: write_reg(CFG_BETA, $urandom_range(0, 300000));
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(CFG_GAMMA, 32'hFF_FFFF);
                1: write_reg(CFG_GAMMA, 32'd0);
                default: write_reg(CFG_GAMMA, $urandom_range(0, 32'hFF_FFFF));
            endcase
            n_items = (eff_width() == STORE_DEPTH) ? 30 : $urandom_range(40, 120);
            for (k = 0; k < n_items; k++) begin
                quiet = (rnd > RAND_ITEMS - 100);
                // many requests still to come in this batch
                in_batch = (k + 20 < n_items);
                if ($urandom_range(0, 9) < 7) begin
                    step = int'(pv) + $urandom_range(0, 16) - 8;
                    pv = (step < 0) ? 8'd0 : (step > 255) ? 8'd255 : 8'(step);
                end else begin
                    pv = $urandom_range(0, 255);
                end
                send_pixel(pv, $urandom_range(0, 59) == 0, 0, '0);
                rnd++;
            end
            in_batch = 0;
        end

        drain();
        $display("covered %0d pixels, %0d weight sets, %0d register writes",
                 pixels_sent, sets_checked, reg_writes);
        $display("widths 0..4095, beta and gamma at both ends, frame restarts, long output stall");
        if (errors == 0) begin
            $display("[graph_cut_edge_weight_gen] OK");
        end else begin
            $display("[graph_cut_edge_weight_gen] ERROR");
        end
        $finish;
    end

endmodule
